// ===== sv/assert_macros.svh =====
// assertion macros shared by the warp scalarization picker modules
// expects i_clk and i_rst_n in the scope of every use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// check on every edge outside reset
`define ASSERT_CHK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// check on every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define ASSERT_CHK(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== sv/wtsp_pkg.sv =====
// types and constants of the warp thread scalarization picker
// no dependencies
package wtsp_pkg;

    localparam int CNT_W      = 4;
    localparam int TID_W      = 5;
    localparam int WARP_W     = 6;
    localparam int PC_W       = 32;
    localparam int MASK_W     = 32;
    localparam int MODE_W     = 3;
    localparam int PLACED_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // request modes
    localparam logic [MODE_W-1:0] MODE_COUNT     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SCALARIZE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_ELECT     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_RELEASE   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_CLEAR     = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WARP_NUMBER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_LIMIT   = 2'd1;

    localparam logic [CNT_W-1:0]  SAT_LIMIT_RESET = 4'd4;
    localparam logic [PC_W-1:0]   NOT_DIVERGENT   = '1;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [MASK_W-1:0] lane_mask;
        logic [PC_W-1:0]   current_pc;
        logic [PC_W-1:0]   reconverge_pc;
        logic [TID_W-1:0]  clear_thread;
    } t_in;

    typedef struct packed {
        logic [PLACED_W-1:0] scalarized_count;
        logic                elected_valid;
        logic [TID_W-1:0]    elected_thread;
        logic [WARP_W-1:0]   elected_warp;
        logic [PC_W-1:0]     elected_start_pc;
        logic [PC_W-1:0]     elected_reconverge_pc;
        logic                divergent;
        logic [MASK_W-1:0]   scalar_threads;
    } t_out;

endpackage

// ===== sv/wtsp_pick.sv =====
// candidate gather and slot assignment for a scalarize request
// depends on wtsp_pkg
module wtsp_pick #(
    parameter int THREADS = 32,
    parameter int SLOTS   = 4
) (
    input  logic [THREADS-1:0][wtsp_pkg::CNT_W-1:0] i_counters,
    input  logic [THREADS-1:0]                      i_scalar,
    input  logic [wtsp_pkg::CNT_W-1:0]              i_limit,
    input  logic [SLOTS-1:0]                        i_filled,
    output logic [SLOTS-1:0]                        o_fill,
    output logic [SLOTS-1:0][wtsp_pkg::TID_W-1:0]   o_fill_tid,
    output logic [THREADS-1:0]                      o_take,
    output logic [$clog2(SLOTS+1)-1:0]              o_placed
);
    import wtsp_pkg::*;

    localparam int RW = $clog2(SLOTS + 1);

    logic [THREADS-1:0]         w_cand;
    logic [THREADS-1:0][RW-1:0] w_rank;
    logic [SLOTS-1:0][RW-1:0]   w_frank;
    logic [SLOTS-1:0][RW-1:0]   w_tgt;
    logic [RW-1:0]              w_ncand;
    logic [RW-1:0]              w_nfree;

    // candidates and their ascending rank, saturating at the slot count
    always_comb begin
        w_ncand = '0;
        for (int t = 0; t < THREADS; t++) begin
            w_cand[t] = (i_counters[t] >= i_limit) && !i_scalar[t];
            w_rank[t] = w_ncand;
            if (w_cand[t] && (w_ncand != RW'(SLOTS))) begin
                w_ncand = w_ncand + RW'(1);
            end
        end
    end

    // rank of each free slot, lowest first
    always_comb begin
        w_nfree = '0;
        for (int s = 0; s < SLOTS; s++) begin
            w_frank[s] = w_nfree;
            if (!i_filled[s]) begin
                w_nfree = w_nfree + RW'(1);
            end
        end
    end

    assign o_placed = (w_ncand < w_nfree) ? w_ncand : w_nfree;

    // lowest free slot takes the highest gathered candidate
    always_comb begin
        o_take     = '0;
        o_fill_tid = '0;
        for (int s = 0; s < SLOTS; s++) begin
            o_fill[s] = !i_filled[s] && (w_frank[s] < w_ncand);
            w_tgt[s]  = w_ncand - RW'(1) - w_frank[s];
            for (int t = 0; t < THREADS; t++) begin
                if (o_fill[s] && w_cand[t] && (w_rank[t] == w_tgt[s])) begin
                    o_take[t]     = 1'b1;
                    o_fill_tid[s] = TID_W'(t);
                end
            end
        end
    end

endmodule

// ===== sv/wtsp_core.sv =====
// per-warp divergence state: thread counters, scalar mask, slots, election
// depends on wtsp_pkg, wtsp_pick and assert_macros.svh
`include "assert_macros.svh"
module wtsp_core #(
    parameter int THREADS = 32,
    parameter int SLOTS   = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  wtsp_pkg::t_in                i_item,
    input  logic [wtsp_pkg::WARP_W-1:0]  i_warp,
    input  logic [wtsp_pkg::CNT_W-1:0]   i_limit,
    output wtsp_pkg::t_out               o_result
);
    import wtsp_pkg::*;

    localparam int RW        = $clog2(SLOTS + 1);
    localparam int PW        = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LOW_THR   = (THREADS < MASK_W) ? THREADS : MASK_W;

    // control state
    logic [THREADS-1:0][CNT_W-1:0] r_cnt,    n_cnt;
    logic [THREADS-1:0]            r_scalar, n_scalar;
    logic [SLOTS-1:0]              r_filled, n_filled;
    logic [PW-1:0]                 r_ptr,    n_ptr;
    logic                          r_held,   n_held;
    // payload state
    logic [SLOTS-1:0][TID_W-1:0]   r_slot_tid, n_slot_tid;
    logic [SLOTS-1:0][PC_W-1:0]    r_slot_pc,  n_slot_pc;
    logic [SLOTS-1:0][PC_W-1:0]    r_slot_rpc, n_slot_rpc;
    logic [TID_W-1:0]              r_held_tid,  n_held_tid;
    logic [WARP_W-1:0]             r_held_warp, n_held_warp;
    logic [PC_W-1:0]               r_held_pc,   n_held_pc;
    logic [PC_W-1:0]               r_held_rpc,  n_held_rpc;

    logic                          w_div;
    logic [SLOTS-1:0]              w_fill;
    logic [SLOTS-1:0][TID_W-1:0]   w_fill_tid;
    logic [THREADS-1:0]            w_take;
    logic [RW-1:0]                 w_placed;
    logic [RW-1:0]                 w_placed_out;

    logic                          w_scal_fire;
    logic                          w_elect_fire;
    int                            w_scalar_gain;
    int                            w_fill_gain;

    assign w_div = (i_item.reconverge_pc != NOT_DIVERGENT);

    wtsp_pick #(
        .THREADS (THREADS),
        .SLOTS   (SLOTS)
    ) u_pick (
        .i_counters (r_cnt),
        .i_scalar   (r_scalar),
        .i_limit    (i_limit),
        .i_filled   (r_filled),
        .o_fill     (w_fill),
        .o_fill_tid (w_fill_tid),
        .o_take     (w_take),
        .o_placed   (w_placed)
    );

    // next state for the request in flight
    always_comb begin
        n_cnt        = r_cnt;
        n_scalar     = r_scalar;
        n_filled     = r_filled;
        n_ptr        = r_ptr;
        n_held       = r_held;
        n_slot_tid   = r_slot_tid;
        n_slot_pc    = r_slot_pc;
        n_slot_rpc   = r_slot_rpc;
        n_held_tid   = r_held_tid;
        n_held_warp  = r_held_warp;
        n_held_pc    = r_held_pc;
        n_held_rpc   = r_held_rpc;
        w_placed_out = '0;
        if (i_fire) begin
            case (i_item.mode)
                MODE_COUNT: begin
                    if (w_div) begin
                        for (int t = 0; t < LOW_THR; t++) begin
                            if (i_item.lane_mask[t] && (r_cnt[t] < i_limit)) begin
                                n_cnt[t] = r_cnt[t] + CNT_W'(1);
                            end
                        end
                    end
                end
                MODE_SCALARIZE: begin
                    if (w_div) begin
                        w_placed_out = w_placed;
                        for (int s = 0; s < SLOTS; s++) begin
                            if (w_fill[s]) begin
                                n_filled[s]   = 1'b1;
                                n_slot_tid[s] = w_fill_tid[s];
                                n_slot_pc[s]  = i_item.current_pc;
                                n_slot_rpc[s] = i_item.reconverge_pc;
                            end
                        end
                        for (int t = 0; t < THREADS; t++) begin
                            if (w_take[t]) begin
                                n_cnt[t]    = '0;
                                n_scalar[t] = 1'b1;
                            end
                        end
                    end
                end
                MODE_ELECT: begin
                    if (!r_held) begin
                        if (r_filled[r_ptr]) begin
                            n_held          = 1'b1;
                            n_held_tid      = r_slot_tid[r_ptr];
                            n_held_warp     = i_warp;
                            n_held_pc       = r_slot_pc[r_ptr];
                            n_held_rpc      = r_slot_rpc[r_ptr];
                            n_filled[r_ptr] = 1'b0;
                        end
                        n_ptr = (r_ptr == PW'(SLOTS - 1)) ? '0 : r_ptr + PW'(1);
                    end
                end
                MODE_RELEASE: begin
                    n_held = 1'b0;
                end
                MODE_CLEAR: begin
                    n_cnt = '0;
                    for (int t = 0; t < THREADS; t++) begin
                        if (t == int'(i_item.clear_thread)) begin
                            n_scalar[t] = 1'b0;
                        end
                    end
                    for (int s = 0; s < SLOTS; s++) begin
                        if (r_filled[s] && (r_slot_tid[s] == i_item.clear_thread)) begin
                            n_filled[s]   = 1'b0;
                            n_slot_tid[s] = '0;
                            n_slot_pc[s]  = '0;
                            n_slot_rpc[s] = '0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result from the state after this request
    always_comb begin
        o_result                       = '0;
        o_result.scalarized_count      = PLACED_W'(w_placed_out);
        o_result.elected_valid         = n_held;
        o_result.elected_thread        = n_held ? n_held_tid  : '0;
        o_result.elected_warp          = n_held ? n_held_warp : '0;
        o_result.elected_start_pc      = n_held ? n_held_pc   : '0;
        o_result.elected_reconverge_pc = n_held ? n_held_rpc  : '0;
        o_result.divergent             = w_div;
        for (int t = 0; t < LOW_THR; t++) begin
            o_result.scalar_threads[t] = n_scalar[t];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_scalar <= '0;
            r_filled <= '0;
            r_ptr    <= '0;
            r_held   <= 1'b0;
        end else begin
            r_cnt    <= n_cnt;
            r_scalar <= n_scalar;
            r_filled <= n_filled;
            r_ptr    <= n_ptr;
            r_held   <= n_held;
        end
    end

    // slot and held entry payload
    always_ff @(posedge i_clk) begin
        r_slot_tid  <= n_slot_tid;
        r_slot_pc   <= n_slot_pc;
        r_slot_rpc  <= n_slot_rpc;
        r_held_tid  <= n_held_tid;
        r_held_warp <= n_held_warp;
        r_held_pc   <= n_held_pc;
        r_held_rpc  <= n_held_rpc;
    end

    // terms for the checks below
    assign w_scal_fire   = i_fire && (i_item.mode == MODE_SCALARIZE);
    assign w_elect_fire  = i_fire && (i_item.mode == MODE_ELECT);
    assign w_scalar_gain = $countones(n_scalar) - $countones(r_scalar);
    assign w_fill_gain   = $countones(n_filled) - $countones(r_filled);

    `ASSERT_CHK(a_ptr_range, r_ptr <= PW'(SLOTS - 1), "slot pointer beyond last slot")
    `ASSERT_CHK(a_held_by_elect, $rose(r_held) |-> $past(w_elect_fire), "held without elect")
    `ASSERT_CHK(a_scalar_growth, w_scal_fire |-> (w_scalar_gain == int'(w_placed_out)), "scalar gain")
    `ASSERT_CHK(a_fill_growth, w_scal_fire |-> (w_fill_gain == int'(w_placed_out)), "slot fill gain")

endmodule

// ===== sv/warp_thread_scalarization_picker_unit.sv =====
// top level of the warp thread scalarization picker
// depends on wtsp_pkg, wtsp_core and assert_macros.svh
//
// Usage:
// - request channel (i_in_valid / o_in_ready / i_in) carries one warp event:
//   count, scalarize, elect, release or clear
// - result channel (o_out_valid / i_out_ready / o_out) returns one result per
//   request: placed count, held election, divergence and the scalar mask
// - configuration channel (i_cfg_valid / o_cfg_ready / i_cfg_index /
//   i_cfg_data) sets warp number and saturation limit, always ready; the user
//   must write it only while no request is outstanding; the block does not check
// - an accepted request sits in the input register, where its state update and
//   result are computed; they are loaded into the result register once that
//   register is free or being taken, and o_out_valid rises with that load
// - throughput: one request per cycle while results are taken; the single pass
//   of the core between input register and result register sets this
// - a stalled receiver holds the result register; one more request waits in
//   the input register, then o_in_ready drops
// - reset clears counters, scalar mask, slots, the slot pointer and the held
//   election; the saturation limit returns to 4 and the warp number to 0
`include "assert_macros.svh"
module warp_thread_scalarization_picker_unit #(
    parameter int THREADS = 32,
    parameter int SLOTS   = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  wtsp_pkg::t_in                    i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output wtsp_pkg::t_out                   o_out,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [wtsp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [wtsp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import wtsp_pkg::*;

    logic              r_in_valid;
    t_in               r_in;
    logic              r_out_valid;
    t_out              r_out;
    logic [WARP_W-1:0] r_warp;
    logic [CNT_W-1:0]  r_limit;

    logic              w_in_acc;
    logic              w_adv;
    t_out              w_result;

    // handshake: the input register moves on when the result register is free
    assign w_adv       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_adv;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    wtsp_core #(
        .THREADS (THREADS),
        .SLOTS   (SLOTS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_adv),
        .i_item   (r_in),
        .i_warp   (r_warp),
        .i_limit  (r_limit),
        .o_result (w_result)
    );

    // valid flags and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_warp      <= '0;
            r_limit     <= SAT_LIMIT_RESET;
        end else begin
            if (w_in_acc) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_WARP_NUMBER: r_warp  <= i_cfg_data[WARP_W-1:0];
                    CFG_SAT_LIMIT:   r_limit <= i_cfg_data[CNT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // request and result payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in <= i_in;
        end
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    `ASSERT_CHK(a_in_hold, !o_in_ready |=> (r_in_valid && $stable(r_in)), "waiting request changed")
    `ASSERT_CHK(a_ready_low, !o_in_ready |-> (r_in_valid && r_out_valid), "stall with free register")
    `ASSERT_CHK(a_out_drop, $fell(r_out_valid) |-> $past(i_out_ready), "result dropped untaken")

endmodule

// ===== verif/tb.sv =====
// testbench for warp_thread_scalarization_picker_unit: random and directed warp requests,
// each result checked against a cycle-free model of the counters, slots and election
// depends on wtsp_pkg and the picker rtl
`timescale 1ns / 100ps

module tb;
    import wtsp_pkg::*;

    localparam int THREADS     = 32;
    localparam int SLOTS       = 4;
    localparam int LONG_HOLD   = 80;
    localparam int QUIET_LIMIT = 1000;

    // modes the block treats as no-ops, and a register index it ignores
    localparam logic [MODE_W-1:0]    MODE_SPARE_5 = 3'd5;
    localparam logic [MODE_W-1:0]    MODE_SPARE_6 = 3'd6;
    localparam logic [MODE_W-1:0]    MODE_SPARE_7 = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE    = 2'd3;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in                   i_in        = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out                  o_out;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    warp_thread_scalarization_picker_unit #(
        .THREADS(THREADS),
        .SLOTS  (SLOTS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    // model state, starts at reset values
    logic [WARP_W-1:0] warp_id   = '0;
    logic [CNT_W-1:0]  limit_model = SAT_LIMIT_RESET;
    logic [CNT_W-1:0]  thread_count [THREADS] = '{default: '0};
    logic [MASK_W-1:0] scalar_model = '0;
    logic              slot_used [SLOTS] = '{default: 1'b0};
    logic [TID_W-1:0]  slot_tid  [SLOTS] = '{default: '0};
    logic [PC_W-1:0]   slot_pc   [SLOTS] = '{default: '0};
    logic [PC_W-1:0]   slot_rpc  [SLOTS] = '{default: '0};
    logic [1:0]        rr_ptr    = '0;
    logic              held      = 1'b0;
    logic [TID_W-1:0]  held_tid  = '0;
    logic [WARP_W-1:0] held_warp = '0;
    logic [PC_W-1:0]   held_pc   = '0;
    logic [PC_W-1:0]   held_rpc  = '0;

    t_in  request_backlog [$];
    t_out expected_results [$];

    int items_queued    = 0;
    int results_checked = 0;
    int mismatches      = 0;
    int threads_placed  = 0;
    int elections       = 0;
    int reg_writes      = 0;
    int quiet_cycles    = 0;
    int hold_requests   = 0;
    int holds_served    = 0;
    int tx_gap          = 0;
    int rx_stall        = 0;
    int rx_hold_left    = 0;
    bit tx_no_gap       = 1'b0;
    bit rx_no_stall     = 1'b0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // next state and result of the picker for one request
    function automatic t_out apply_request(input t_in r);
        t_out             o;
        logic [TID_W-1:0] picks [SLOTS];
        logic [TID_W-1:0] t_sel;
        logic             div;
        int               n;
        int               placed;
        int               t;
        int               s;
        o      = '0;
        n      = 0;
        placed = 0;
        div    = (r.reconverge_pc != NOT_DIVERGENT);
        case (r.mode)
            MODE_COUNT: begin
                if (div) begin
                    for (t = 0; t < THREADS; t++)
                        if (r.lane_mask[t] && thread_count[t] < limit_model)
                            thread_count[t] = thread_count[t] + 1'b1;
                end
            end
            MODE_SCALARIZE: begin
                if (div) begin
                    // lowest saturated threads gathered, highest of them placed first
                    for (t = 0; t < THREADS && n < SLOTS; t++) begin
                        if (thread_count[t] >= limit_model && !scalar_model[t]) begin
                            picks[n] = TID_W'(t);
                            n++;
                        end
                    end
                    for (s = 0; s < SLOTS; s++) begin
                        if (!slot_used[s] && n > 0) begin
                            n--;
                            t_sel               = picks[n];
                            thread_count[t_sel] = '0;
                            scalar_model[t_sel] = 1'b1;
                            slot_used[s]        = 1'b1;
                            slot_tid[s]         = t_sel;
                            slot_pc[s]          = r.current_pc;
                            slot_rpc[s]         = r.reconverge_pc;
                            placed++;
                        end
                    end
                end
            end
            MODE_ELECT: begin
                // pointer frozen while an election is held
                if (!held) begin
                    if (slot_used[rr_ptr]) begin
                        held             = 1'b1;
                        held_tid         = slot_tid[rr_ptr];
                        held_warp        = warp_id;
                        held_pc          = slot_pc[rr_ptr];
                        held_rpc         = slot_rpc[rr_ptr];
                        slot_used[rr_ptr] = 1'b0;
                        elections++;
                    end
                    // four slots, so the 2-bit pointer wraps by itself
                    rr_ptr = rr_ptr + 1'b1;
                end
            end
            MODE_RELEASE: held = 1'b0;
            MODE_CLEAR: begin
                for (t = 0; t < THREADS; t++)
                    thread_count[t] = '0;
                scalar_model[r.clear_thread] = 1'b0;
                for (s = 0; s < SLOTS; s++) begin
                    if (slot_used[s] && slot_tid[s] == r.clear_thread) begin
                        slot_used[s] = 1'b0;
                        slot_tid[s]  = '0;
                        slot_pc[s]   = '0;
                        slot_rpc[s]  = '0;
                    end
                end
            end
            default: ;
        endcase
        threads_placed          += placed;
        o.scalarized_count      = PLACED_W'(placed);
        o.elected_valid         = held;
        o.elected_thread        = held ? held_tid : '0;
        o.elected_warp          = held ? held_warp : '0;
        o.elected_start_pc      = held ? held_pc : '0;
        o.elected_reconverge_pc = held ? held_rpc : '0;
        o.divergent             = div;
        o.scalar_threads        = scalar_model;
        return o;
    endfunction

    function automatic t_in make_request(input logic [MODE_W-1:0] mode,
                                         input logic [MASK_W-1:0] mask,
                                         input logic [PC_W-1:0] pc,
                                         input logic [PC_W-1:0] rpc,
                                         input logic [TID_W-1:0] tid);
        t_in r;
        r.mode          = mode;
        r.lane_mask     = mask;
        r.current_pc    = pc;
        r.reconverge_pc = rpc;
        r.clear_thread  = tid;
        return r;
    endfunction

    function automatic logic [PC_W-1:0] divergent_pc();
        logic [PC_W-1:0] v;
        v = $urandom;
        if (v == NOT_DIVERGENT)
            v = '0;
        return v;
    endfunction

    function automatic logic [MASK_W-1:0] pick_mask();
        case ($urandom_range(0, 3))
            0:       return '1;
            1:       return $urandom;
            2:       return $urandom & $urandom & $urandom;
            default: return 32'd1 << $urandom_range(0, 31);
        endcase
    endfunction

    function automatic logic [TID_W-1:0] any_tid();
        return TID_W'($urandom_range(0, 31));
    endfunction

    task automatic queue_request(input t_in r);
        request_backlog = {request_backlog, r};
        items_queued++;
    endtask

    // mostly well-formed count / scalarize / elect sequences, some raw noise
    task automatic push_random(input int count, input int longest_run);
        int               start;
        logic [PC_W-1:0]  pc;
        logic [PC_W-1:0]  rpc;
        logic [TID_W-1:0] tid;
        start = items_queued;
        while (items_queued - start < count) begin
            if ($urandom_range(0, 4) != 0) begin
                rpc = divergent_pc();
                pc  = $urandom;
                repeat ($urandom_range(1, longest_run))
                    queue_request(make_request(MODE_COUNT, pick_mask(), pc, rpc,
                                               any_tid()));
                queue_request(make_request(MODE_SCALARIZE, $urandom, pc, rpc,
                                           any_tid()));
                repeat ($urandom_range(1, 4)) begin
                    queue_request(make_request(MODE_ELECT, $urandom, $urandom, $urandom,
                                               any_tid()));
                    if ($urandom_range(0, 3) != 0)
                        queue_request(make_request(MODE_RELEASE, $urandom, $urandom,
                                                   $urandom, any_tid()));
                end
                if ($urandom_range(0, 2) == 0) begin
                    // low threads get scalarized first, so aim clears there often
                    tid = $urandom_range(0, 1) ? TID_W'($urandom_range(0, 7))
                                               : any_tid();
                    queue_request(make_request(MODE_CLEAR, $urandom, $urandom, $urandom, tid));
                end
            end else begin
                rpc = $urandom_range(0, 1) ? NOT_DIVERGENT : $urandom;
                queue_request(make_request(MODE_W'($urandom_range(0, 7)), $urandom, $urandom,
                                           rpc, any_tid()));
            end
        end
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        reg_writes++;
        if (idx == CFG_WARP_NUMBER)
            warp_id = data[WARP_W-1:0];
        else if (idx == CFG_SAT_LIMIT)
            limit_model = data[CNT_W-1:0];
    endtask

    // every request answered, then the pipeline left to settle
    task automatic wait_drained();
        while (results_checked < items_queued) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result %h with no request outstanding", got);
        end else begin
            want = expected_results[0];
            expected_results.delete(0);
            if (got.scalarized_count !== want.scalarized_count ||
                got.elected_valid !== want.elected_valid ||
                got.elected_thread !== want.elected_thread ||
                got.elected_warp !== want.elected_warp ||
                got.elected_start_pc !== want.elected_start_pc ||
                got.elected_reconverge_pc !== want.elected_reconverge_pc ||
                got.divergent !== want.divergent ||
                got.scalar_threads !== want.scalar_threads) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("result %0d mismatch (exp/got): placed %0d/%0d held %b/%b",
                             results_checked, want.scalarized_count, got.scalarized_count,
                             want.elected_valid, got.elected_valid);
                    $display("  thread %0d/%0d warp %0d/%0d pc %h/%h rpc %h/%h",
                             want.elected_thread, got.elected_thread,
                             want.elected_warp, got.elected_warp,
                             want.elected_start_pc, got.elected_start_pc,
                             want.elected_reconverge_pc, got.elected_reconverge_pc);
                    $display("  divergent %b/%b scalar %h/%h",
                             want.divergent, got.divergent,
                             want.scalar_threads, got.scalar_threads);
                end
            end
        end
    endtask

    // request driver: predicts on accept, then offers the next request, after a random gap unless gaps are off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_results = {expected_results, apply_request(i_in)};
                tx_gap = tx_no_gap ? 0 : $urandom_range(0, 9);
            end
            if (!i_in_valid || o_in_ready) begin
                if (tx_gap > 0 || request_backlog.size() == 0) begin
                    i_in_valid <= 1'b0;
                    if (tx_gap > 0)
                        tx_gap--;
                end else begin
                    i_in       <= request_backlog[0];
                    i_in_valid <= 1'b1;
                    request_backlog.delete(0);
                end
            end
        end
    end

    // result monitor with random stalls and an occasional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            rx_stall     = 0;
            rx_hold_left = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                check_result(o_out);
                results_checked++;
                rx_stall = rx_no_stall ? 0 : $urandom_range(0, 9);
            end
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                rx_hold_left = LONG_HOLD;
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                i_out_ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("no handshake for %0d cycles", QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed pass at reset settings
        // not divergent: count and scalarize leave state alone
        queue_request(make_request(MODE_COUNT, '1, '0, NOT_DIVERGENT, '0));
        queue_request(make_request(MODE_SCALARIZE, '1, '1, NOT_DIVERGENT, '1));
        // saturate every thread, then fill all slots from threads 3..0
        repeat (4) queue_request(make_request(MODE_COUNT, '1, '0, 32'd0, '0));
        queue_request(make_request(MODE_SCALARIZE, '0, '1, 32'd0, '0));
        // no free slot left
        queue_request(make_request(MODE_SCALARIZE, '0, 32'h1234_5678, 32'h0000_0040, '0));
        // elect, elect while held, release, elect the next slot
        queue_request(make_request(MODE_ELECT, '0, '0, '0, '0));
        queue_request(make_request(MODE_ELECT, '0, '0, '0, '0));
        queue_request(make_request(MODE_RELEASE, '0, '0, '0, '0));
        queue_request(make_request(MODE_ELECT, '0, '0, '0, '0));
        // clear a slotted thread, then the top thread id
        queue_request(make_request(MODE_CLEAR, '0, '0, '0, 5'd0));
        queue_request(make_request(MODE_CLEAR, '1, '1, '1, 5'd31));
        // release twice, the second with nothing held
        queue_request(make_request(MODE_RELEASE, '0, '0, '0, '0));
        queue_request(make_request(MODE_RELEASE, '1, '1, '1, '1));
        // unused modes
        queue_request(make_request(MODE_SPARE_5, '1, '1, '0, '1));
        queue_request(make_request(MODE_SPARE_6, '0, '0, '1, '0));
        queue_request(make_request(MODE_SPARE_7, '1, '0, 32'hFFFF_FFFE, '1));
        // count on edge threads with a near-all-ones rpc
        queue_request(make_request(MODE_COUNT, 32'h8000_0001, '0, 32'hFFFF_FFFE, '0));
        // elect remaining slot, release, then visit the cleared and the empty slot
        queue_request(make_request(MODE_ELECT, '0, '0, '0, '0));
        queue_request(make_request(MODE_RELEASE, '0, '0, '0, '0));
        queue_request(make_request(MODE_ELECT, '0, '0, '0, '0));
        queue_request(make_request(MODE_ELECT, '0, '0, '0, '0));
        wait_drained();

        // smallest nonzero limit, top warp id
        write_register(CFG_WARP_NUMBER, 6'd63);
        write_register(CFG_SAT_LIMIT, 6'd1);
        push_random(150, 5);
        wait_drained();

        // largest limit; receiver holds off while the sender keeps offering
        write_register(CFG_WARP_NUMBER, 6'h2A);
        write_register(CFG_SAT_LIMIT, 6'd15);
        tx_no_gap = 1'b1;
        hold_requests++;
        push_random(150, 18);
        wait_drained();
        tx_no_gap = 1'b0;

        // zero limit makes every non-scalar thread a candidate; no idling at all
        write_register(CFG_SAT_LIMIT, 6'd0);
        write_register(CFG_WARP_NUMBER, 6'd0);
        write_register(CFG_SPARE, '1);
        tx_no_gap   = 1'b1;
        rx_no_stall = 1'b1;
        push_random(130, 5);
        wait_drained();
        tx_no_gap   = 1'b0;
        rx_no_stall = 1'b0;

        // upper data bits above the limit field are dropped
        write_register(CFG_SAT_LIMIT, 6'h32);
        write_register(CFG_WARP_NUMBER, CFG_DATA_W'($urandom_range(0, 63)));
        push_random(150, 6);
        wait_drained();

        // back to the reset limit
        write_register(CFG_SAT_LIMIT, CFG_DATA_W'(SAT_LIMIT_RESET));
        write_register(CFG_WARP_NUMBER, CFG_DATA_W'($urandom_range(0, 63)));
        push_random(150, 8);
        wait_drained();

        if (expected_results.size() != 0) begin
            $display("%0d expected results never arrived", expected_results.size());
            mismatches += expected_results.size();
        end
        $display("%0d requests over %0d register writes, %0d results checked",
                 items_queued, reg_writes, results_checked);
        $display("%0d threads scalarized, %0d elections, %0d mismatches",
                 threads_placed, elections, mismatches);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/wtsp_pkg.sv
sv/wtsp_pick.sv
sv/wtsp_core.sv
sv/warp_thread_scalarization_picker_unit.sv
verif/tb.sv
